[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module pmc_checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define PMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Concurrent assertion that stays active through reset.
`define PMC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/pmc_pkg.sv]
package pmc_pkg;

  // Fixed field widths of the stream beats.
  localparam int unsigned STR_W   = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CUT_W   = 6;
  localparam int unsigned ORDER_W = 2;
  localparam int unsigned OUT_W   = 8;

  // Result codes, two's complement in two bits.
  localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'b11;
  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'b01;

  // What one lane says about the comparison.
  typedef enum logic [1:0] {
    DEC_NEXT    = 2'd0,
    DEC_LESS    = 2'd1,
    DEC_EQUAL   = 2'd2,
    DEC_GREATER = 2'd3
  } lane_dec_e;

  // Top flags of both measures.
  typedef struct packed {
    logic a_top;
    logic b_top;
  } top_flags_t;

endpackage

[hw/rtl/pmc_lane.sv]
module pmc_lane #(
  parameter int unsigned LEVEL_BITS = 6
) (
  input  logic [pmc_pkg::STR_W-1:0] ab_i,
  input  logic [pmc_pkg::STR_W-1:0] am_i,
  input  logic [pmc_pkg::STR_W-1:0] bb_i,
  input  logic [pmc_pkg::STR_W-1:0] bm_i,
  input  logic [LEVEL_BITS-1:0]     al_i,
  input  logic [LEVEL_BITS-1:0]     bl_i,
  input  logic [pmc_pkg::CUT_W-1:0] cut_i,
  input  logic                      a_here_i,
  input  logic                      b_here_i,
  output pmc_pkg::lane_dec_e        dec_o
);

  localparam int unsigned CMP_W =
    (LEVEL_BITS > pmc_pkg::CUT_W) ? LEVEL_BITS : pmc_pkg::CUT_W;

  logic [pmc_pkg::STR_W-1:0] s, x, f, d, w, dw, q, p;
  logic                      a_less, b_less, a_gt, b_gt;
  logic [CMP_W-1:0]          al_x, bl_x, cut_x;
  logic                      al_above, bl_above;
  pmc_pkg::lane_dec_e        a_bit_dec, b_bit_dec;

  // String arithmetic on the shared prefix, wrapping at eight bits.
  always_comb begin
    s      = am_i & bm_i;
    x      = am_i ^ bm_i;
    f      = x & ~(x << 1);
    d      = ab_i ^ bb_i;
    w      = s + f;
    dw     = d & w;
    a_less = ((am_i < bm_i) && (dw == f)) || ((am_i > bm_i) && (dw == '0));
    b_less = ((bm_i < am_i) && (dw == f)) || ((bm_i > am_i) && (dw == '0));
    q      = s & d;
    p      = q & (~q + pmc_pkg::STR_W'(1));
    a_gt   = |(ab_i & p);
    b_gt   = |(bb_i & p);
  end

  // Levels against the cut, at a common width.
  always_comb begin
    al_x     = CMP_W'(al_i);
    bl_x     = CMP_W'(bl_i);
    cut_x    = CMP_W'(cut_i);
    al_above = al_x > cut_x;
    bl_above = bl_x > cut_x;
  end

  // A lane that stands alone decides by its lowest string bit.
  always_comb begin
    a_bit_dec = ab_i[0] ? pmc_pkg::DEC_GREATER : pmc_pkg::DEC_LESS;
    b_bit_dec = bb_i[0] ? pmc_pkg::DEC_LESS : pmc_pkg::DEC_GREATER;
  end

  // Lane decision in the order of the scan rules.
  always_comb begin
    priority if (a_here_i && !b_here_i) begin
      dec_o = a_bit_dec;
    end else if (!a_here_i && b_here_i) begin
      dec_o = b_bit_dec;
    end else if (!a_here_i && !b_here_i) begin
      dec_o = pmc_pkg::DEC_EQUAL;
    end else if (al_above && bl_above) begin
      dec_o = pmc_pkg::DEC_EQUAL;
    end else if ((!al_above && bl_above) || (al_i < bl_i)) begin
      dec_o = a_bit_dec;
    end else if ((al_above && !bl_above) || (al_i > bl_i)) begin
      dec_o = b_bit_dec;
    end else if (a_gt || (!a_less && b_less)) begin
      dec_o = pmc_pkg::DEC_GREATER;
    end else if (b_gt || (a_less && !b_less)) begin
      dec_o = pmc_pkg::DEC_LESS;
    end else begin
      dec_o = pmc_pkg::DEC_NEXT;
    end
  end

endmodule

[hw/rtl/pmc_merge.sv]
module pmc_merge #(
  parameter int unsigned LANES = 8
) (
  input  pmc_pkg::top_flags_t          tops_i,
  input  pmc_pkg::lane_dec_e           dec_i [LANES],
  output logic [pmc_pkg::ORDER_W-1:0]  order_o
);

  logic                         found;
  logic [pmc_pkg::ORDER_W-1:0]  scan_order;

  // The lowest lane that decides fixes the result.
  always_comb begin
    found      = 1'b0;
    scan_order = pmc_pkg::ORDER_EQUAL;
    for (int unsigned i = 0; i < LANES; i++) begin
      if (!found && (dec_i[i] != pmc_pkg::DEC_NEXT)) begin
        found = 1'b1;
        unique case (dec_i[i])
          pmc_pkg::DEC_LESS:    scan_order = pmc_pkg::ORDER_LESS;
          pmc_pkg::DEC_GREATER: scan_order = pmc_pkg::ORDER_GREATER;
          default:              scan_order = pmc_pkg::ORDER_EQUAL;
        endcase
      end
    end
  end

  // Top overrides the lane scan.
  always_comb begin
    priority if (tops_i.a_top && tops_i.b_top) begin
      order_o = pmc_pkg::ORDER_EQUAL;
    end else if (tops_i.a_top) begin
      order_o = pmc_pkg::ORDER_GREATER;
    end else if (tops_i.b_top) begin
      order_o = pmc_pkg::ORDER_LESS;
    end else begin
      order_o = scan_order;
    end
  end

endmodule

[hw/rtl/progress_measure_compare_core.sv]
// Channel   Dir  Contents
// s_axis    in   tdata: measures a and b with cut level; tuser: top flags
// m_axis    out  tdata: order (-1, 0, 1)
//
// One beat is accepted per cycle unless both stages are full and stalled.
// The lanes decide in the first stage and the merge scan runs in the second.
// Reset clears both valid flags; no clearing pass is needed.
// A stalled output holds the lane stage only when that stage is full.
module progress_measure_compare_core #(
  parameter int unsigned LANES      = 8,
  parameter int unsigned LEVEL_BITS = 6,
  localparam int unsigned BITS_W    = pmc_pkg::STR_W * LANES,
  localparam int unsigned LVL_W     = LEVEL_BITS * LANES,
  localparam int unsigned IN_W      = 4 * BITS_W + 2 * LVL_W + 2 * pmc_pkg::CNT_W
                                      + pmc_pkg::CUT_W,
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // From bit 0: a_bits, a_masks, a_levels, a_count,
  // b_bits, b_masks, b_levels, b_count, cut_level, zero fill
  input  logic [IN_TDATA_W-1:0]       s_axis_tdata,
  // From bit 0: a_top, b_top
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // From bit 0: order, zero fill
  output logic [pmc_pkg::OUT_W-1:0]   m_axis_tdata
);

  localparam int unsigned A_BITS_LO = 0;
  localparam int unsigned A_MASK_LO = A_BITS_LO + BITS_W;
  localparam int unsigned A_LVL_LO  = A_MASK_LO + BITS_W;
  localparam int unsigned A_CNT_LO  = A_LVL_LO + LVL_W;
  localparam int unsigned B_BITS_LO = A_CNT_LO + pmc_pkg::CNT_W;
  localparam int unsigned B_MASK_LO = B_BITS_LO + BITS_W;
  localparam int unsigned B_LVL_LO  = B_MASK_LO + BITS_W;
  localparam int unsigned B_CNT_LO  = B_LVL_LO + LVL_W;
  localparam int unsigned CUT_LO    = B_CNT_LO + pmc_pkg::CNT_W;

  localparam logic [pmc_pkg::CNT_W-1:0] CNT_ONE = pmc_pkg::CNT_W'(1);
  localparam logic [pmc_pkg::CNT_W-1:0] CNT_MAX = pmc_pkg::CNT_W'(LANES);

  logic [pmc_pkg::CNT_W-1:0]  a_cnt_raw, b_cnt_raw, a_cnt, b_cnt;
  logic [pmc_pkg::CUT_W-1:0]  cut;
  logic                       s_fire, lane_ready, out_ready;

  pmc_pkg::lane_dec_e         dec_d [LANES];
  pmc_pkg::lane_dec_e         dec_q [LANES];
  pmc_pkg::top_flags_t        tops_d, tops_q;
  logic                       lane_valid_q;

  logic [pmc_pkg::ORDER_W-1:0] order_d, order_q;
  logic                        out_valid_q;

  // Handshake: each stage moves when the one after it is free.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign lane_ready    = !lane_valid_q || out_ready;
  assign s_axis_tready = lane_ready;
  assign s_fire        = s_axis_tvalid && lane_ready;

  // Saturate lane counts into the range one to LANES.
  always_comb begin
    a_cnt_raw = s_axis_tdata[A_CNT_LO +: pmc_pkg::CNT_W];
    b_cnt_raw = s_axis_tdata[B_CNT_LO +: pmc_pkg::CNT_W];
    cut       = s_axis_tdata[CUT_LO +: pmc_pkg::CUT_W];
    priority if (a_cnt_raw == '0) begin
      a_cnt = CNT_ONE;
    end else if (a_cnt_raw > CNT_MAX) begin
      a_cnt = CNT_MAX;
    end else begin
      a_cnt = a_cnt_raw;
    end
    priority if (b_cnt_raw == '0) begin
      b_cnt = CNT_ONE;
    end else if (b_cnt_raw > CNT_MAX) begin
      b_cnt = CNT_MAX;
    end else begin
      b_cnt = b_cnt_raw;
    end
    tops_d.a_top = s_axis_tuser[0];
    tops_d.b_top = s_axis_tuser[1];
  end

  // One comparison lane per element of the measures.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pmc_lane #(
      .LEVEL_BITS(LEVEL_BITS)
    ) u_lane (
      .ab_i     (s_axis_tdata[A_BITS_LO + pmc_pkg::STR_W * g +: pmc_pkg::STR_W]),
      .am_i     (s_axis_tdata[A_MASK_LO + pmc_pkg::STR_W * g +: pmc_pkg::STR_W]),
      .bb_i     (s_axis_tdata[B_BITS_LO + pmc_pkg::STR_W * g +: pmc_pkg::STR_W]),
      .bm_i     (s_axis_tdata[B_MASK_LO + pmc_pkg::STR_W * g +: pmc_pkg::STR_W]),
      .al_i     (s_axis_tdata[A_LVL_LO + LEVEL_BITS * g +: LEVEL_BITS]),
      .bl_i     (s_axis_tdata[B_LVL_LO + LEVEL_BITS * g +: LEVEL_BITS]),
      .cut_i    (cut),
      .a_here_i (a_cnt > pmc_pkg::CNT_W'(g)),
      .b_here_i (b_cnt > pmc_pkg::CNT_W'(g)),
      .dec_o    (dec_d[g])
    );
  end

  // Lane stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else if (lane_ready) begin
      lane_valid_q <= s_axis_tvalid;
    end
  end

  // Lane stage payload.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      dec_q  <= dec_d;
      tops_q <= tops_d;
    end
  end

  // Merge the lane decisions into one order.
  pmc_merge #(
    .LANES(LANES)
  ) u_merge (
    .tops_i  (tops_q),
    .dec_i   (dec_q),
    .order_o (order_d)
  );

  // Output stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= lane_valid_q;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk_i) begin
    if (out_ready && lane_valid_q) begin
      order_q <= order_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(pmc_pkg::OUT_W - pmc_pkg::ORDER_W){1'b0}}, order_q};

endmodule

[hw/rtl/pmc_checker.sv]
`include "assert_macros.svh"

module pmc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [pmc_pkg::OUT_W-1:0] m_axis_tdata
);

  logic order_ok, out_stall, in_fire;

  // Legal output beats carry one of the three order codes over zero fill.
  assign order_ok = (m_axis_tdata[pmc_pkg::OUT_W-1:pmc_pkg::ORDER_W] == '0) &&
                    ((m_axis_tdata[pmc_pkg::ORDER_W-1:0] == pmc_pkg::ORDER_LESS) ||
                     (m_axis_tdata[pmc_pkg::ORDER_W-1:0] == pmc_pkg::ORDER_EQUAL) ||
                     (m_axis_tdata[pmc_pkg::ORDER_W-1:0] == pmc_pkg::ORDER_GREATER));
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // The output beat carries one of the three order codes and zero fill.
  `PMC_ASSERT(a_order_code, m_axis_tvalid |-> order_ok, "order beat carries an invalid code")

  // Input stalls only while a finished result waits downstream.
  `PMC_ASSERT(a_stall_cause, !s_axis_tready |-> out_stall, "input stalled with free output")

  // A new result follows an accepted beat through the lane and output registers.
  `PMC_ASSERT(a_latency, $rose(m_axis_tvalid) |-> $past(in_fire, 2), "result without input beat")

  // A result that is not taken stays unchanged.
  `PMC_ASSERT(a_out_hold, out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // Reset empties the output.
  `PMC_ASSERT_RST(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind progress_measure_compare_core pmc_checker u_pmc_checker (.*);

[verif/pmc_order_checker.sv]
`timescale 1ns / 100ps

// Watches both stream channels of the comparator, predicts the order of every
// accepted input beat and checks each output beat against the oldest prediction.
module pmc_order_checker #(
  parameter int unsigned LANES      = 8,
  parameter int unsigned LEVEL_BITS = 6,
  localparam int unsigned BITS_W    = pmc_pkg::STR_W * LANES,
  localparam int unsigned LVL_W     = LEVEL_BITS * LANES,
  localparam int unsigned IN_W      = 4 * BITS_W + 2 * LVL_W + 2 * pmc_pkg::CNT_W
                                      + pmc_pkg::CUT_W,
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  // From bit 0: a_bits, a_masks, a_levels, a_count,
  // b_bits, b_masks, b_levels, b_count, cut_level, zero fill
  input  logic [IN_TDATA_W-1:0]     s_tdata_i,
  // From bit 0: a_top, b_top
  input  logic [1:0]                s_tuser_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  // From bit 0: order, zero fill
  input  logic [pmc_pkg::OUT_W-1:0] m_tdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  // Bit offsets of the fields inside one input beat.
  localparam int unsigned A_BITS_LO = 0;
  localparam int unsigned A_MASK_LO = A_BITS_LO + BITS_W;
  localparam int unsigned A_LVL_LO  = A_MASK_LO + BITS_W;
  localparam int unsigned A_CNT_LO  = A_LVL_LO + LVL_W;
  localparam int unsigned B_BITS_LO = A_CNT_LO + pmc_pkg::CNT_W;
  localparam int unsigned B_MASK_LO = B_BITS_LO + BITS_W;
  localparam int unsigned B_LVL_LO  = B_MASK_LO + BITS_W;
  localparam int unsigned B_CNT_LO  = B_LVL_LO + LVL_W;
  localparam int unsigned CUT_LO    = B_CNT_LO + pmc_pkg::CNT_W;

  logic [pmc_pkg::OUT_W-1:0] order_q[$];
  logic [pmc_pkg::OUT_W-1:0] want;
  logic [pmc_pkg::OUT_W-1:0] fresh;

  // Saturate a lane count into the range 1..LANES.
  function automatic int unsigned clamp_lanes(logic [pmc_pkg::CNT_W-1:0] c);
    if (c == '0) return 1;
    if (c > LANES) return LANES;
    return 32'(c);
  endfunction

  // Order of measure a against measure b for one input beat.
  function automatic logic [pmc_pkg::ORDER_W-1:0] predict_order(
      logic [1:0] tops, logic [IN_TDATA_W-1:0] beat);
    logic [pmc_pkg::STR_W-1:0] ab, am, bb, bm, s, x, f, d, w, dw, q, p;
    logic [LEVEL_BITS-1:0]     al, bl;
    logic [pmc_pkg::CUT_W-1:0] cut;
    int unsigned               ac, bc, n;
    logic                      a_less, b_less, a_gt, b_gt;

    // Top dominates everything else.
    if (tops[0] && tops[1]) return pmc_pkg::ORDER_EQUAL;
    if (tops[0]) return pmc_pkg::ORDER_GREATER;
    if (tops[1]) return pmc_pkg::ORDER_LESS;

    ac  = clamp_lanes(beat[A_CNT_LO +: pmc_pkg::CNT_W]);
    bc  = clamp_lanes(beat[B_CNT_LO +: pmc_pkg::CNT_W]);
    n   = (ac > bc) ? ac : bc;
    cut = beat[CUT_LO +: pmc_pkg::CUT_W];

    // Scan the lanes upward until one of them decides.
    for (int i = 0; i < n; i++) begin
      ab = beat[A_BITS_LO + pmc_pkg::STR_W * i +: pmc_pkg::STR_W];
      am = beat[A_MASK_LO + pmc_pkg::STR_W * i +: pmc_pkg::STR_W];
      bb = beat[B_BITS_LO + pmc_pkg::STR_W * i +: pmc_pkg::STR_W];
      bm = beat[B_MASK_LO + pmc_pkg::STR_W * i +: pmc_pkg::STR_W];
      al = beat[A_LVL_LO + LEVEL_BITS * i +: LEVEL_BITS];
      bl = beat[B_LVL_LO + LEVEL_BITS * i +: LEVEL_BITS];

      if (i >= bc) return ab[0] ? pmc_pkg::ORDER_GREATER : pmc_pkg::ORDER_LESS;
      if (i >= ac) return bb[0] ? pmc_pkg::ORDER_LESS : pmc_pkg::ORDER_GREATER;
      if (al > cut && bl > cut) return pmc_pkg::ORDER_EQUAL;
      if ((al <= cut && bl > cut) || al < bl)
        return ab[0] ? pmc_pkg::ORDER_GREATER : pmc_pkg::ORDER_LESS;
      if ((al > cut && bl <= cut) || al > bl)
        return bb[0] ? pmc_pkg::ORDER_LESS : pmc_pkg::ORDER_GREATER;

      // Same level: compare the strings with wrapping byte arithmetic.
      s  = am & bm;
      x  = am ^ bm;
      f  = x & ~(x << 1);
      d  = ab ^ bb;
      w  = s + f;
      dw = d & w;
      a_less = (am < bm && dw == f) || (am > bm && dw == '0);
      b_less = (bm < am && dw == f) || (bm > am && dw == '0);
      q  = s & d;
      p  = q & (~q + pmc_pkg::STR_W'(1));
      a_gt = (q != '0) && ((ab & p) != '0);
      b_gt = (q != '0) && ((bb & p) != '0);

      if (a_gt || (!a_less && b_less)) return pmc_pkg::ORDER_GREATER;
      if (b_gt || (a_less && !b_less)) return pmc_pkg::ORDER_LESS;
    end
    return pmc_pkg::ORDER_EQUAL;
  endfunction

  // Match output beats first, then record the prediction for a new input beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (order_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          $display("%0t: result beat with none pending, expected none, actual %h",
                   $time, m_tdata_i);
        end else begin
          want = order_q.pop_front();
          if (m_tdata_i !== want) begin
            fail_count_o <= fail_count_o + 1;
            $display("%0t: order mismatch, expected %h, actual %h",
                     $time, want, m_tdata_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        fresh   = {{(pmc_pkg::OUT_W - pmc_pkg::ORDER_W){1'b0}},
                   predict_order(s_tuser_i, s_tdata_i)};
        order_q = {order_q, fresh};
      end
      pending_o <= order_q.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LANES      = 8;
  localparam int unsigned LEVEL_BITS = 6;
  localparam int unsigned BITS_W     = pmc_pkg::STR_W * LANES;
  localparam int unsigned LVL_W      = LEVEL_BITS * LANES;
  localparam int unsigned IN_W       = 4 * BITS_W + 2 * LVL_W + 2 * pmc_pkg::CNT_W
                                       + pmc_pkg::CUT_W;
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  // One comparison request, both measures and the cut level.
  typedef struct packed {
    logic                      a_top;
    logic                      b_top;
    logic [BITS_W-1:0]         a_bits;
    logic [BITS_W-1:0]         a_masks;
    logic [LVL_W-1:0]          a_levels;
    logic [pmc_pkg::CNT_W-1:0] a_count;
    logic [BITS_W-1:0]         b_bits;
    logic [BITS_W-1:0]         b_masks;
    logic [LVL_W-1:0]          b_levels;
    logic [pmc_pkg::CNT_W-1:0] b_count;
    logic [pmc_pkg::CUT_W-1:0] cut;
  } cmp_req_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_W-1:0]     s_axis_tdata;
  logic [1:0]                s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [pmc_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      calm;
  int                        fail_count;
  int                        pending;

  progress_measure_compare_core #(
    .LANES      (LANES),
    .LEVEL_BITS (LEVEL_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pmc_order_checker #(
    .LANES      (LANES),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_order_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Free-running clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Two identical measures with random strings, all levels at zero.
  function automatic cmp_req_t tie_req(int unsigned cnt, int unsigned cut);
    cmp_req_t r;
    r.a_top    = 1'b0;
    r.b_top    = 1'b0;
    r.a_bits   = {$urandom, $urandom};
    r.a_masks  = {$urandom, $urandom};
    r.a_levels = '0;
    r.a_count  = pmc_pkg::CNT_W'(cnt);
    r.b_bits   = r.a_bits;
    r.b_masks  = r.a_masks;
    r.b_levels = '0;
    r.b_count  = pmc_pkg::CNT_W'(cnt);
    r.cut      = pmc_pkg::CUT_W'(cut);
    return r;
  endfunction

  // Mostly measures that share a prefix of tied lanes and then differ in one
  // lane, so that the scan runs deep; the rest is unconstrained noise.
  function automatic cmp_req_t random_req();
    cmp_req_t                  r;
    logic [BITS_W-1:0]         bits, masks, bbits, bmasks;
    logic [LVL_W-1:0]          lvls, blvls;
    logic [pmc_pkg::CUT_W-1:0] cut;
    logic [7:0]                lane;
    int unsigned               k;

    cut = pmc_pkg::CUT_W'($urandom_range(0, 63));
    bits = {$urandom, $urandom};
    for (int i = 0; i < LANES; i++) begin
      lane = ($urandom_range(0, 1) == 0) ? (8'hFF >> $urandom_range(0, 8)) : 8'($urandom);
      masks[8 * i +: 8] = lane;
      lvls[LEVEL_BITS * i +: LEVEL_BITS] = LEVEL_BITS'(($urandom_range(0, 99) < 85) ?
          $urandom_range(0, cut) : $urandom_range(0, 63));
    end
    bbits  = bits;
    bmasks = masks;
    blvls  = lvls;

    // Break the tie at one lane, or at none.
    k = $urandom_range(0, LANES);
    if (k < LANES) begin
      case ($urandom_range(0, 3))
        0: bbits[8 * k +: 8] = bbits[8 * k +: 8] ^ 8'($urandom_range(1, 255));
        1: bmasks[8 * k +: 8] = 8'($urandom);
        2: blvls[LEVEL_BITS * k +: LEVEL_BITS] = LEVEL_BITS'($urandom);
        default: begin
          bbits[8 * k +: 8]  = 8'($urandom);
          bmasks[8 * k +: 8] = 8'($urandom);
        end
      endcase
    end

    r.a_bits   = bits;
    r.a_masks  = masks;
    r.a_levels = lvls;
    r.a_count  = pmc_pkg::CNT_W'($urandom_range(1, LANES));
    r.b_bits   = bbits;
    r.b_masks  = bmasks;
    r.b_levels = blvls;
    r.b_count  = ($urandom_range(0, 1) == 0) ? r.a_count : 4'($urandom_range(1, LANES));
    r.cut      = cut;

    if ($urandom_range(0, 9) < 3) begin
      r.a_bits   = {$urandom, $urandom};
      r.a_masks  = {$urandom, $urandom};
      r.a_levels = LVL_W'({$urandom, $urandom});
      r.a_count  = pmc_pkg::CNT_W'($urandom_range(0, 15));
      r.b_bits   = {$urandom, $urandom};
      r.b_masks  = {$urandom, $urandom};
      r.b_levels = LVL_W'({$urandom, $urandom});
      r.b_count  = pmc_pkg::CNT_W'($urandom_range(0, 15));
    end
    r.a_top = ($urandom_range(0, 19) == 0);
    r.b_top = ($urandom_range(0, 19) == 0);
    return r;
  endfunction

  // Present one request and hold it until the beat is taken.
  task automatic send_req(input cmp_req_t r);
    s_axis_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, r.cut, r.b_count, r.b_levels,
                      r.b_masks, r.b_bits, r.a_count, r.a_levels, r.a_masks, r.a_bits};
    s_axis_tuser  <= {r.b_top, r.a_top};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Result side: stall now and then, never during the calm stretch.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Run limit.
  initial begin
    #200000;
    $display("testbench: FAIL");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    cmp_req_t r;

    rst_ni        <= 1'b0;
    calm          <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Top against Top, Top on either side.
    r = tie_req(8, 63); r.a_top = 1'b1; r.b_top = 1'b1; send_req(r);
    r = tie_req(8, 63); r.a_top = 1'b1; send_req(r);
    r = tie_req(8, 63); r.b_top = 1'b1; send_req(r);

    // Identical measures run the scan to its end; all-zero and all-one fields.
    r = tie_req(8, 63); send_req(r);
    r = tie_req(8, 0); send_req(r);
    r = '0; r.a_count = 4'd1; r.b_count = 4'd1; send_req(r);
    r = '1; r.a_top = 1'b0; r.b_top = 1'b0; send_req(r);

    // Saturated counts: zero and values above the lane count.
    r = tie_req(0, 63); r.b_count = 4'd15; send_req(r);

    // Lanes present in only one of the measures.
    r = tie_req(2, 63); r.b_count = 4'd1; r.a_bits[8] = 1'b0; send_req(r);
    r.a_bits[8] = 1'b1; send_req(r);
    r = tie_req(1, 63); r.b_count = 4'd3; r.b_bits[8] = 1'b0; send_req(r);
    r.b_bits[8] = 1'b1; send_req(r);

    // Both levels beyond the cut stop the scan.
    r = tie_req(4, 0); r.a_levels = '1; r.b_levels = '1; send_req(r);

    // One level lower than the other, and one within the cut with the other beyond.
    r = tie_req(4, 10); r.a_levels[5:0] = 6'd1; r.b_levels[5:0] = 6'd2; send_req(r);
    r = tie_req(4, 10); r.a_levels[5:0] = 6'd3; r.b_levels[5:0] = 6'd1; send_req(r);
    r = tie_req(4, 5); r.a_levels[5:0] = 6'd5; r.b_levels[5:0] = 6'd6; send_req(r);
    r = tie_req(4, 5); r.a_levels[5:0] = 6'd6; r.b_levels[5:0] = 6'd5; send_req(r);

    // Different mask lengths with equal strings.
    r = tie_req(3, 63); r.a_masks[7:0] = 8'h0F; r.b_masks[7:0] = 8'h3F; send_req(r);
    r = tie_req(3, 63); r.a_masks[7:0] = 8'h3F; r.b_masks[7:0] = 8'h0F; send_req(r);

    // Shared full-length prefix that differs in one bit, either way round.
    r = tie_req(3, 63); r.a_masks[7:0] = 8'hFF; r.b_masks[7:0] = 8'hFF;
    r.a_bits[7:0] = 8'h08; r.b_bits[7:0] = 8'h00; send_req(r);
    r.a_bits[7:0] = 8'h00; r.b_bits[7:0] = 8'h08; send_req(r);

    // Random part with sender gaps, one drain pause and one calm stretch.
    for (int n = 0; n < 900; n++) begin
      calm <= (n >= 400 && n < 550);
      if (n == 300) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (!(n >= 400 && n < 550) && $urandom_range(0, 99) < 5) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      send_req(random_req());
    end
    s_axis_tvalid <= 1'b0;

    // Drain the pipeline, then wait on for stray beats.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[progress_measure_compare_core.f]
+incdir+hw/rtl
hw/rtl/pmc_pkg.sv
hw/rtl/pmc_lane.sv
hw/rtl/pmc_merge.sv
hw/rtl/progress_measure_compare_core.sv
hw/rtl/pmc_checker.sv
verif/pmc_order_checker.sv
verif/testbench.sv
